### hdl/cyclic_palette_supersample_colorizer_defines.svh
// Assertion macros for the palette colorizer.
// Used by hdl/cyclic_palette_supersample_colorizer.sv; expects i_clk and i_rst_n in scope.
`ifndef CYCLIC_PALETTE_SUPERSAMPLE_COLORIZER_DEFINES_SVH
`define CYCLIC_PALETTE_SUPERSAMPLE_COLORIZER_DEFINES_SVH

// Same-cycle implication, sampled on i_clk, off during reset
`define CPSC_CHECK_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on i_clk, off during reset
`define CPSC_CHECK_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hdl/cpsc_pkg.sv
// Shared widths and codes for the cyclic palette colorizer.
// No dependencies; imported by cyclic_palette_supersample_colorizer.
package cpsc_pkg;

    // Field and state widths
    localparam int ITER_W      = 24;
    localparam int PAL_DEPTH   = 16;
    localparam int PAL_AW      = $clog2(PAL_DEPTH);
    localparam int COL_W       = 8;
    localparam int RGB_W       = 3 * COL_W;
    localparam int MAX_SAMPLES = 64;
    localparam int SPP_W       = 7;
    localparam int NCOL_W      = 5;
    localparam int SCNT_W      = 6;
    localparam int SUM_W       = 14;
    localparam int PIX_W       = 24;

    // Configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 24;

    localparam logic [CFG_IDX_W-1:0] CFG_CYCLE_LENGTH      = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SAMPLES_PER_PIXEL = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_COLOR_COUNT       = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_PIXEL_COUNT       = 2'd3;

    // Request types
    localparam logic REQ_SAMPLE  = 1'b0;
    localparam logic REQ_PALETTE = 1'b1;

    // Shared divider: dividend width and step counter width
    localparam int DIV_W     = 32;
    localparam int DIV_CNT_W = $clog2(DIV_W);

    // Channel selects
    localparam logic [1:0] CH_RED   = 2'd0;
    localparam logic [1:0] CH_GREEN = 2'd1;
    localparam logic [1:0] CH_BLUE  = 2'd2;

endpackage

### hdl/cyclic_palette_supersample_colorizer.sv
// Usage: cyclic gradient palette colorizer with supersample averaging.
// Input channel (i_in_valid / o_in_stall) carries either a palette write word
// (i_req_type = 1) or one iteration-count sample (i_req_type = 0). Output
// channel (o_out_valid / i_out_stall) carries one averaged pixel word after
// every samples_per_pixel samples; o_frame_end marks the last pixel of a frame.
// Config channel (i_cfg_valid / o_cfg_ready) writes the four registers at any
// time; o_cfg_ready is always high. Write them only while the block is idle.
// Timing: one item at a time. A palette write and an in-set sample use no
// division. An escaped sample runs the modulo, the segment split, the two
// palette memory reads and three blends; completing a pixel adds three
// averages. Every division goes through the shared one-bit-per-cycle divider.
// A finished pixel sits in the output register; the next word is accepted
// while it waits. A second pixel waits in its emit state until the output
// register is taken.
// Reset: synchronous, active low. Clears the sums and counters and loads the
// register defaults (cycle 256, 1 sample, 2 colors, 1 pixel). Palette
// contents are undefined until written.
`include "cyclic_palette_supersample_colorizer_defines.svh"

module cyclic_palette_supersample_colorizer (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // Input channel
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  logic                            i_req_type,
    input  logic [cpsc_pkg::ITER_W-1:0]     i_iter_count,
    input  logic                            i_in_set,
    input  logic [cpsc_pkg::PAL_AW-1:0]     i_palette_index,
    input  logic [cpsc_pkg::COL_W-1:0]      i_palette_red,
    input  logic [cpsc_pkg::COL_W-1:0]      i_palette_green,
    input  logic [cpsc_pkg::COL_W-1:0]      i_palette_blue,
    // Output channel
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output logic [cpsc_pkg::COL_W-1:0]      o_pixel_red,
    output logic [cpsc_pkg::COL_W-1:0]      o_pixel_green,
    output logic [cpsc_pkg::COL_W-1:0]      o_pixel_blue,
    output logic                            o_frame_end,
    // Configuration channel
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [cpsc_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [cpsc_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import cpsc_pkg::*;

    localparam int VN_W = ITER_W + PAL_AW;

    typedef enum logic [11:0] {
        S_IDLE  = 12'b0000_0000_0001,
        S_MOD   = 12'b0000_0000_0010,
        S_SEG   = 12'b0000_0000_0100,
        S_RDL   = 12'b0000_0000_1000,
        S_RDR   = 12'b0000_0001_0000,
        S_MULA  = 12'b0000_0010_0000,
        S_MULB  = 12'b0000_0100_0000,
        S_BLEND = 12'b0000_1000_0000,
        S_ACC   = 12'b0001_0000_0000,
        S_AVGL  = 12'b0010_0000_0000,
        S_AVG   = 12'b0100_0000_0000,
        S_EMIT  = 12'b1000_0000_0000
    } t_state;

    // Pick one 8-bit channel out of a packed {red, green, blue} entry
    function automatic logic [COL_W-1:0] chan_of(input logic [RGB_W-1:0] rgb,
                                                 input logic [1:0] ch);
        logic [COL_W-1:0] res;
        unique case (ch)
            CH_RED:   res = rgb[3*COL_W-1:2*COL_W];
            CH_GREEN: res = rgb[2*COL_W-1:COL_W];
            CH_BLUE:  res = rgb[COL_W-1:0];
            default:  res = '0;
        endcase
        return res;
    endfunction

    // Configuration registers
    logic [ITER_W-1:0] r_cycle_length;
    logic [SPP_W-1:0]  r_samples_per_pixel;
    logic [NCOL_W-1:0] r_color_count;
    logic [PIX_W-1:0]  r_pixel_count;

    // Control and accumulation state
    t_state            r_state, n_state;
    logic [1:0]        r_chan;
    logic [SUM_W-1:0]  r_sum [3];
    logic [SCNT_W-1:0] r_samp_cnt;
    logic [PIX_W-1:0]  r_pix_cnt;

    // Datapath registers
    logic [PAL_AW-1:0] r_seg;
    logic [ITER_W-1:0] r_frac;
    logic [RGB_W-1:0]  r_left;
    logic [DIV_W-1:0]  r_num;
    logic [COL_W-1:0]  r_avg [3];

    // Palette memory
    logic [RGB_W-1:0]  r_palette [PAL_DEPTH];
    logic [RGB_W-1:0]  r_pal_q;
    logic              pal_rd_en;
    logic [PAL_AW-1:0] pal_raddr;

    // Shared divider
    logic [DIV_W-1:0]     r_div_quo, n_div_quo;
    logic [ITER_W-1:0]    r_div_rem, n_div_rem;
    logic [ITER_W-1:0]    r_div_den;
    logic [DIV_CNT_W-1:0] r_div_cnt;
    logic                 r_div_run;
    logic                 div_load;
    logic [DIV_W-1:0]     div_num;
    logic [ITER_W-1:0]    div_den;
    logic [ITER_W:0]      div_trial;
    logic                 div_ge;

    // Output register
    logic              r_out_valid;
    logic [COL_W-1:0]  r_pixel_red, r_pixel_green, r_pixel_blue;
    logic              r_frame_end;

    // Effective configuration and helpers
    logic [ITER_W-1:0] len_eff;
    logic [SPP_W-1:0]  spp_eff;
    logic [NCOL_W-1:0] ncol_eff;
    logic [PAL_AW-1:0] ncol_m1;
    logic [PIX_W-1:0]  pcount_eff;
    logic [VN_W-1:0]   vn_prod;
    logic [ITER_W-1:0] frac_left;
    logic [DIV_W-1:0]  mul_left;
    logic [DIV_W-1:0]  blend_num;
    logic              in_accept;
    logic              out_free;
    logic              sample_more;
    logic              frame_last;
    logic              emit_fire;
    logic [SUM_W-1:0]  sum_sel;

    // Clamp registers into their working ranges
    always_comb begin
        len_eff = (r_cycle_length == '0) ? ITER_W'(1) : r_cycle_length;
        if (r_samples_per_pixel == '0) begin
            spp_eff = SPP_W'(1);
        end else if (r_samples_per_pixel > SPP_W'(MAX_SAMPLES)) begin
            spp_eff = SPP_W'(MAX_SAMPLES);
        end else begin
            spp_eff = r_samples_per_pixel;
        end
        if (r_color_count < NCOL_W'(2)) begin
            ncol_eff = NCOL_W'(2);
        end else if (r_color_count > NCOL_W'(PAL_DEPTH)) begin
            ncol_eff = NCOL_W'(PAL_DEPTH);
        end else begin
            ncol_eff = r_color_count;
        end
        pcount_eff = (r_pixel_count == '0) ? PIX_W'(1) : r_pixel_count;
    end

    assign ncol_m1 = PAL_AW'(ncol_eff - NCOL_W'(1));

    // Handshakes
    assign o_in_stall  = (r_state != S_IDLE);
    assign in_accept   = i_in_valid && !o_in_stall;
    assign out_free    = !r_out_valid || !i_out_stall;
    assign emit_fire   = (r_state == S_EMIT) && out_free;
    assign o_cfg_ready = 1'b1;

    // Arithmetic around the divider
    assign vn_prod   = r_div_rem * ncol_m1;
    assign frac_left = len_eff - r_frac;
    assign mul_left  = chan_of(r_left, r_chan) * frac_left;
    assign blend_num = r_num + chan_of(r_pal_q, r_chan) * r_frac;
    assign sum_sel   = r_sum[r_chan];

    assign sample_more = ({1'b0, r_samp_cnt} + SPP_W'(1)) < spp_eff;
    assign frame_last  = ({1'b0, r_pix_cnt} + (PIX_W+1)'(1)) >= {1'b0, pcount_eff};

    // Sequencer: next state and divider launch
    always_comb begin
        n_state  = r_state;
        div_load = 1'b0;
        div_num  = '0;
        div_den  = len_eff;
        unique case (r_state)
            S_IDLE: begin
                if (in_accept && (i_req_type == REQ_SAMPLE)) begin
                    if (i_in_set) begin
                        n_state = S_ACC;
                    end else begin
                        div_load = 1'b1;
                        div_num  = {{(DIV_W-ITER_W){1'b0}}, i_iter_count};
                        n_state  = S_MOD;
                    end
                end
            end
            S_MOD: begin
                if (!r_div_run) begin
                    div_load = 1'b1;
                    div_num  = {{(DIV_W-VN_W){1'b0}}, vn_prod};
                    n_state  = S_SEG;
                end
            end
            S_SEG: begin
                if (!r_div_run) begin
                    n_state = S_RDL;
                end
            end
            S_RDL:  n_state = S_RDR;
            S_RDR:  n_state = S_MULA;
            S_MULA: n_state = S_MULB;
            S_MULB: begin
                div_load = 1'b1;
                div_num  = blend_num;
                n_state  = S_BLEND;
            end
            S_BLEND: begin
                if (!r_div_run) begin
                    n_state = (r_chan == CH_BLUE) ? S_ACC : S_MULA;
                end
            end
            S_ACC: n_state = sample_more ? S_IDLE : S_AVGL;
            S_AVGL: begin
                div_load = 1'b1;
                div_num  = {{(DIV_W-SUM_W){1'b0}}, sum_sel};
                div_den  = {{(ITER_W-SPP_W){1'b0}}, spp_eff};
                n_state  = S_AVG;
            end
            S_AVG: begin
                if (!r_div_run) begin
                    n_state = (r_chan == CH_BLUE) ? S_EMIT : S_AVGL;
                end
            end
            S_EMIT: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Divider step: shift in one dividend bit, subtract if it fits
    always_comb begin
        div_trial = {r_div_rem, r_div_quo[DIV_W-1]};
        div_ge    = div_trial >= {1'b0, r_div_den};
        n_div_rem = div_ge ? ITER_W'(div_trial - {1'b0, r_div_den})
                           : div_trial[ITER_W-1:0];
        n_div_quo = {r_div_quo[DIV_W-2:0], div_ge};
    end

    // Divider operands and partial results
    always_ff @(posedge i_clk) begin
        if (div_load) begin
            r_div_quo <= div_num;
            r_div_rem <= '0;
            r_div_den <= div_den;
        end else if (r_div_run) begin
            r_div_quo <= n_div_quo;
            r_div_rem <= n_div_rem;
        end
    end

    // Divider control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_div_run <= 1'b0;
            r_div_cnt <= '0;
        end else if (div_load) begin
            r_div_run <= 1'b1;
            r_div_cnt <= '0;
        end else if (r_div_run) begin
            r_div_cnt <= r_div_cnt + DIV_CNT_W'(1);
            if (r_div_cnt == DIV_CNT_W'(DIV_W - 1)) begin
                r_div_run <= 1'b0;
            end
        end
    end

    // Palette memory: write on palette words, read in the two fetch states
    assign pal_rd_en = (r_state == S_RDL) || (r_state == S_RDR);
    assign pal_raddr = (r_state == S_RDR) ? (r_seg + PAL_AW'(1)) : r_seg;

    always_ff @(posedge i_clk) begin
        if (in_accept && (i_req_type == REQ_PALETTE)) begin
            r_palette[i_palette_index] <= {i_palette_red, i_palette_green, i_palette_blue};
        end
        if (pal_rd_en) begin
            r_pal_q <= r_palette[pal_raddr];
        end
    end

    // Datapath captures
    always_ff @(posedge i_clk) begin
        if ((r_state == S_SEG) && !r_div_run) begin
            r_seg  <= r_div_quo[PAL_AW-1:0];
            r_frac <= r_div_rem;
        end
        if (r_state == S_RDR) begin
            r_left <= r_pal_q;
        end
        if (r_state == S_MULA) begin
            r_num <= mul_left;
        end
        if ((r_state == S_AVG) && !r_div_run) begin
            r_avg[r_chan] <= r_div_quo[COL_W-1:0];
        end
        if (emit_fire) begin
            r_pixel_red   <= r_avg[0];
            r_pixel_green <= r_avg[1];
            r_pixel_blue  <= r_avg[2];
            r_frame_end   <= frame_last;
        end
    end

    // Control state, sums and counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_chan      <= CH_RED;
            r_sum[0]    <= '0;
            r_sum[1]    <= '0;
            r_sum[2]    <= '0;
            r_samp_cnt  <= '0;
            r_pix_cnt   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;

            // Advance the channel through blend and average passes
            if ((r_state == S_SEG) && !r_div_run) begin
                r_chan <= CH_RED;
            end else if ((r_state == S_ACC) && !sample_more) begin
                r_chan <= CH_RED;
            end else if (((r_state == S_BLEND) || (r_state == S_AVG)) && !r_div_run
                         && (r_chan != CH_BLUE)) begin
                r_chan <= r_chan + 2'd1;
            end

            // Add each blended channel into its sum
            if ((r_state == S_BLEND) && !r_div_run) begin
                r_sum[r_chan] <= sum_sel + SUM_W'(r_div_quo[COL_W-1:0]);
            end

            // Count samples of the current pixel
            if (r_state == S_ACC) begin
                r_samp_cnt <= sample_more ? (r_samp_cnt + SCNT_W'(1)) : '0;
            end

            // Hand the pixel over; drop the sums, step the frame position
            if (emit_fire) begin
                r_sum[0]    <= '0;
                r_sum[1]    <= '0;
                r_sum[2]    <= '0;
                r_pix_cnt   <= frame_last ? '0 : (r_pix_cnt + PIX_W'(1));
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cycle_length      <= ITER_W'(256);
            r_samples_per_pixel <= SPP_W'(1);
            r_color_count       <= NCOL_W'(2);
            r_pixel_count       <= PIX_W'(1);
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_CYCLE_LENGTH:      r_cycle_length      <= i_cfg_data[ITER_W-1:0];
                CFG_SAMPLES_PER_PIXEL: r_samples_per_pixel <= i_cfg_data[SPP_W-1:0];
                CFG_COLOR_COUNT:       r_color_count       <= i_cfg_data[NCOL_W-1:0];
                CFG_PIXEL_COUNT:       r_pixel_count       <= i_cfg_data[PIX_W-1:0];
                default: ;
            endcase
        end
    end

    // Output port drive
    assign o_out_valid   = r_out_valid;
    assign o_pixel_red   = r_pixel_red;
    assign o_pixel_green = r_pixel_green;
    assign o_pixel_blue  = r_pixel_blue;
    assign o_frame_end   = r_frame_end;

    // Checks
    `CPSC_CHECK_NOW(a_div_no_reload, div_load, !r_div_run, "divider restarted while busy")
    `CPSC_CHECK_NOW(a_div_rem_bound, r_div_run, r_div_rem < r_div_den, "divider remainder out of range")
    `CPSC_CHECK_NEXT(a_emit_holds, (r_state == S_EMIT) && r_out_valid && i_out_stall, r_state == S_EMIT, "pixel emitted over a stalled word")
    `CPSC_CHECK_NEXT(a_emit_loads, emit_fire, r_out_valid && (r_state == S_IDLE), "emit did not load the output register")

endmodule

### verif/tb_top.sv
// Self-checking testbench for cyclic_palette_supersample_colorizer.
// Streams palette and sample words through a shadow predictor and checks every averaged pixel;
// depends on hdl/cpsc_pkg.sv and the colorizer RTL.
`timescale 1ns / 1ps

module tb_top;
    import cpsc_pkg::*;

    localparam int unsigned SETTLE_CYCLES = 400;
    localparam int unsigned WORD_TARGET   = 1900;

    typedef struct packed {
        logic              req;
        logic [ITER_W-1:0] iter;
        logic              in_set;
        logic [PAL_AW-1:0] slot;
        logic [COL_W-1:0]  red;
        logic [COL_W-1:0]  green;
        logic [COL_W-1:0]  blue;
    } t_color_word;

    typedef struct packed {
        logic [COL_W-1:0] red;
        logic [COL_W-1:0] green;
        logic [COL_W-1:0] blue;
        logic             frame_end;
    } t_pixel;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    // Stimulus side
    logic                  in_valid  = 1'b0;
    t_color_word           cur_word  = '0;
    logic                  out_stall = 1'b0;
    logic                  cfg_valid = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    wire                   o_in_stall;
    wire                   o_out_valid;
    wire [COL_W-1:0]       o_pixel_red;
    wire [COL_W-1:0]       o_pixel_green;
    wire [COL_W-1:0]       o_pixel_blue;
    wire                   o_frame_end;
    wire                   o_cfg_ready;

    // Bookkeeping
    t_color_word word_q[$];
    t_pixel      pixel_q[$];
    int unsigned word_sent  = 0;
    int unsigned word_taken = 0;
    int unsigned cfg_sent   = 0;
    int unsigned cfg_taken  = 0;
    int unsigned words_made = 0;
    int unsigned errors     = 0;
    int unsigned gap_left   = 0;
    int unsigned stall_left = 0;
    int unsigned hold_req   = 0;
    bit          send_idle  = 1'b1;
    bit          stall_idle = 1'b1;

    // Shadow state of the colorizer
    logic [RGB_W-1:0]  pal_shadow [PAL_DEPTH];
    logic [23:0]       cfg_cycle  = 24'd256;
    logic [SPP_W-1:0]  cfg_spp    = 7'd1;
    logic [NCOL_W-1:0] cfg_ncol   = 5'd2;
    logic [PIX_W-1:0]  cfg_pixels = 24'd1;
    int unsigned       sample_cnt = 0;
    int unsigned       pixel_cnt  = 0;
    int unsigned       sum_r      = 0;
    int unsigned       sum_g      = 0;
    int unsigned       sum_b      = 0;

    cyclic_palette_supersample_colorizer i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (in_valid),
        .o_in_stall      (o_in_stall),
        .i_req_type      (cur_word.req),
        .i_iter_count    (cur_word.iter),
        .i_in_set        (cur_word.in_set),
        .i_palette_index (cur_word.slot),
        .i_palette_red   (cur_word.red),
        .i_palette_green (cur_word.green),
        .i_palette_blue  (cur_word.blue),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (out_stall),
        .o_pixel_red     (o_pixel_red),
        .o_pixel_green   (o_pixel_green),
        .o_pixel_blue    (o_pixel_blue),
        .o_frame_end     (o_frame_end),
        .i_cfg_valid     (cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (cfg_index),
        .i_cfg_data      (cfg_data)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Weighted blend of two channel values at position frac out of period
    function automatic int unsigned blend_chan(int unsigned a, int unsigned b,
                                               longint unsigned period,
                                               longint unsigned frac);
        return int'((longint'(a) * (period - frac) + longint'(b) * frac) / period);
    endfunction

    // Advance the shadow colorizer by one accepted word; queue a pixel when one completes
    function automatic void colorize(t_color_word w);
        longint unsigned period, span, seg, frac;
        int unsigned     spp_eff, ncol_eff, frame_len;
        logic [RGB_W-1:0] lo, hi;
        int unsigned     add_r, add_g, add_b;
        bit              last;
        t_pixel          px;
        if (w.req == REQ_PALETTE) begin
            pal_shadow[w.slot] = {w.red, w.green, w.blue};
            return;
        end
        period    = (cfg_cycle == 0) ? 1 : cfg_cycle;
        spp_eff   = (cfg_spp == 0) ? 1 : ((cfg_spp > MAX_SAMPLES) ? MAX_SAMPLES : cfg_spp);
        ncol_eff  = (cfg_ncol < 2) ? 2 : ((cfg_ncol > PAL_DEPTH) ? PAL_DEPTH : cfg_ncol);
        frame_len = (cfg_pixels == 0) ? 1 : cfg_pixels;
        add_r = 0;
        add_g = 0;
        add_b = 0;
        if (!w.in_set) begin
            span = (w.iter % period) * (ncol_eff - 1);
            seg  = span / period;
            frac = span - seg * period;
            lo   = pal_shadow[seg];
            hi   = pal_shadow[seg + 1];
            add_r = blend_chan(lo[23:16], hi[23:16], period, frac);
            add_g = blend_chan(lo[15:8], hi[15:8], period, frac);
            add_b = blend_chan(lo[7:0], hi[7:0], period, frac);
        end
        sum_r += add_r;
        sum_g += add_g;
        sum_b += add_b;
        if (sample_cnt + 1 < spp_eff) begin
            sample_cnt++;
            return;
        end
        last = (pixel_cnt + 1 >= frame_len);
        px.red       = COL_W'(sum_r / spp_eff);
        px.green     = COL_W'(sum_g / spp_eff);
        px.blue      = COL_W'(sum_b / spp_eff);
        px.frame_end = last;
        pixel_q.push_back(px);
        sample_cnt = 0;
        sum_r = 0;
        sum_g = 0;
        sum_b = 0;
        pixel_cnt = last ? 0 : pixel_cnt + 1;
    endfunction

    // Sample handshakes at the rising edge: config writes, input words, output pixels
    always @(posedge i_clk) begin
        t_pixel want;
        if (i_rst_n) begin
            if (o_out_valid && !out_stall) begin
                if (pixel_q.size() == 0) begin
                    $error("pixel with nothing expected: r=%0d g=%0d b=%0d end=%0b",
                           o_pixel_red, o_pixel_green, o_pixel_blue, o_frame_end);
                    errors++;
                end else begin
                    want = pixel_q.pop_front();
                    if (o_pixel_red !== want.red) begin
                        $error("pixel_red expected %0d got %0d", want.red, o_pixel_red);
                        errors++;
                    end
                    if (o_pixel_green !== want.green) begin
                        $error("pixel_green expected %0d got %0d", want.green, o_pixel_green);
                        errors++;
                    end
                    if (o_pixel_blue !== want.blue) begin
                        $error("pixel_blue expected %0d got %0d", want.blue, o_pixel_blue);
                        errors++;
                    end
                    if (o_frame_end !== want.frame_end) begin
                        $error("frame_end expected %0b got %0b", want.frame_end, o_frame_end);
                        errors++;
                    end
                end
            end
            if (cfg_valid && o_cfg_ready) begin
                case (cfg_index)
                    CFG_CYCLE_LENGTH:      cfg_cycle  = cfg_data[23:0];
                    CFG_SAMPLES_PER_PIXEL: cfg_spp    = cfg_data[SPP_W-1:0];
                    CFG_COLOR_COUNT:       cfg_ncol   = cfg_data[NCOL_W-1:0];
                    CFG_PIXEL_COUNT:       cfg_pixels = cfg_data[PIX_W-1:0];
                    default: ;
                endcase
                cfg_taken++;
            end
            if (in_valid && !o_in_stall) begin
                colorize(cur_word);
                word_taken++;
            end
        end
    end

    // Mostly no gap, some short ones, a few long ones
    function automatic int unsigned pick_gap();
        if ($urandom_range(0, 9) < 5)
            return 0;
        if ($urandom_range(0, 9) < 8)
            return $urandom_range(1, 4);
        return $urandom_range(10, 60);
    endfunction

    // Drive the next word once the current one is taken; insert idle gaps
    always @(negedge i_clk) begin
        if (i_rst_n && (!in_valid || word_taken == word_sent)) begin
            if (gap_left > 0) begin
                in_valid <= 1'b0;
                gap_left--;
            end else if (word_q.size() > 0) begin
                cur_word <= word_q.pop_front();
                in_valid <= 1'b1;
                word_sent++;
                gap_left = send_idle ? pick_gap() : 0;
            end else begin
                in_valid <= 1'b0;
            end
        end
    end

    // Stall the output side at random, or for a requested long hold-off
    always @(negedge i_clk) begin
        if (hold_req != 0) begin
            stall_left = hold_req;
            hold_req   = 0;
        end
        if (stall_left > 0) begin
            out_stall <= 1'b1;
            stall_left--;
        end else begin
            out_stall <= 1'b0;
            if (stall_idle && $urandom_range(0, 7) == 0)
                stall_left = pick_gap();
        end
    end

    function automatic logic [ITER_W-1:0] pick_iter();
        longint unsigned period, it;
        period = (cfg_cycle == 0) ? 1 : cfg_cycle;
        case ($urandom_range(0, 5))
            0: it = $urandom_range(0, int'(period - 1));
            1: it = period * $urandom_range(0, 3);
            2: it = period - 1 + $urandom_range(0, 2);
            3: it = $urandom_range(0, 1) ? 24'hFFFFFF : 24'h0;
            default: it = $urandom;
        endcase
        return it[ITER_W-1:0];
    endfunction

    task automatic push_word(t_color_word w);
        word_q.push_back(w);
        words_made++;
    endtask

    // Sample word with random palette fields, which the block ignores
    task automatic push_sample(logic [ITER_W-1:0] iter, logic in_set);
        t_color_word w;
        w        = t_color_word'({$urandom, $urandom, $urandom});
        w.req    = REQ_SAMPLE;
        w.iter   = iter;
        w.in_set = in_set;
        push_word(w);
    endtask

    task automatic push_palette(int unsigned slot, logic [RGB_W-1:0] rgb);
        t_color_word w;
        w      = t_color_word'({$urandom, $urandom, $urandom});
        w.req  = REQ_PALETTE;
        w.slot = slot[PAL_AW-1:0];
        {w.red, w.green, w.blue} = rgb;
        push_word(w);
    endtask

    // Random samples with an occasional palette write mixed in
    task automatic push_mix(int unsigned n);
        for (int unsigned k = 0; k < n; k++) begin
            if ($urandom_range(0, 9) == 0)
                push_palette($urandom_range(0, PAL_DEPTH - 1), RGB_W'($urandom));
            push_sample(pick_iter(), $urandom_range(0, 9) == 0);
        end
    endtask

    // Hold until every word is taken and every pixel is back, then let the block settle
    task automatic drain();
        do @(negedge i_clk);
        while (word_q.size() != 0 || word_taken != word_sent || pixel_q.size() != 0);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    // Called at a falling edge; returns at a falling edge with the write done
    task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, int unsigned data);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data  = data[CFG_DATA_W-1:0];
        cfg_sent++;
        do @(negedge i_clk);
        while (cfg_taken != cfg_sent);
        cfg_valid = 1'b0;
    endtask

    task automatic set_regs(int unsigned cyc, int unsigned spp, int unsigned ncol,
                            int unsigned pix);
        cfg_write(CFG_CYCLE_LENGTH, cyc);
        cfg_write(CFG_SAMPLES_PER_PIXEL, spp);
        cfg_write(CFG_COLOR_COUNT, ncol);
        cfg_write(CFG_PIXEL_COUNT, pix);
    endtask

    initial begin
        int unsigned cyc, spp, ncol, pix, spp_eff, pixels, n;
        repeat (5) @(negedge i_clk);
        i_rst_n = 1'b1;

        // Reset defaults: load the whole palette, then walk one gradient period
        push_palette(0, 24'h000000);
        push_palette(1, 24'hFFFFFF);
        for (int unsigned k = 2; k < PAL_DEPTH; k++)
            push_palette(k, RGB_W'($urandom));
        push_sample(24'd0, 1'b0);
        push_sample(24'd128, 1'b0);
        push_sample(24'd255, 1'b0);
        push_sample(24'd256, 1'b0);
        push_sample(24'hFFFFFF, 1'b0);
        push_sample(24'hFFFFFF, 1'b1);
        drain();

        // Zero registers fall back to their minimums
        set_regs(0, 0, 0, 0);
        push_sample(24'd0, 1'b0);
        push_sample(24'hFFFFFF, 1'b0);
        push_sample(24'd5, 1'b1);
        drain();

        // Color count below two, long frame left part way through
        set_regs(1, 1, 1, 50);
        push_mix(10);
        drain();

        // Register maximums; frame length now below the pixel position
        set_regs(24'hFFFFFF, 127, 31, 2);
        push_sample(24'hFFFFFE, 1'b0);
        push_sample(24'hFFFFFF, 1'b0);
        push_mix(126);
        drain();

        // Full-scale sums: white palette over a whole 64-sample pixel
        set_regs(16, 64, 16, 3);
        for (int unsigned k = 0; k < PAL_DEPTH; k++)
            push_palette(k, 24'hFFFFFF);
        for (int unsigned k = 0; k < 64; k++)
            push_sample(ITER_W'($urandom), 1'b0);
        for (int unsigned k = 0; k < PAL_DEPTH; k++)
            push_palette(k, RGB_W'($urandom));
        drain();

        // Back-pressure: hold the output long enough for the input to stall
        set_regs(256, 1, 4, 5);
        send_idle  = 1'b0;
        stall_idle = 1'b0;
        @(posedge i_clk);
        hold_req = 3000;
        @(negedge i_clk);
        push_mix(12);
        drain();

        // Random settings, one phase at a time
        while (words_made < WORD_TARGET) begin
            case ($urandom_range(0, 9))
                0:       cyc = 0;
                1:       cyc = $urandom_range(1, 8);
                2:       cyc = $urandom_range(301, 65535);
                3:       cyc = $urandom & 24'hFFFFFF;
                4:       cyc = 24'hFFFFFF;
                default: cyc = $urandom_range(9, 300);
            endcase
            case ($urandom_range(0, 9))
                5, 6:    spp = $urandom_range(5, 16);
                7:       spp = $urandom_range(17, 64);
                8:       spp = $urandom_range(65, 127);
                9:       spp = 0;
                default: spp = $urandom_range(1, 4);
            endcase
            ncol = $urandom_range(0, 1) ? $urandom_range(2, 16) : $urandom_range(0, 31);
            case ($urandom_range(0, 7))
                0:       pix = 0;
                1:       pix = $urandom & 24'hFFFFFF;
                default: pix = $urandom_range(1, 6);
            endcase
            set_regs(cyc, spp, ncol, pix);
            send_idle  = $urandom_range(0, 3) != 0;
            stall_idle = $urandom_range(0, 3) != 0;
            spp_eff = (spp == 0) ? 1 : ((spp > MAX_SAMPLES) ? MAX_SAMPLES : spp);
            pixels  = (spp_eff > 16) ? $urandom_range(1, 3) : $urandom_range(2, 12);
            n = pixels * spp_eff;
            // Leave a pixel unfinished now and then across the next register change
            if (spp_eff > 1 && $urandom_range(0, 3) == 0)
                n += $urandom_range(1, spp_eff - 1);
            push_mix(n);
            drain();
        end

        if (errors == 0)
            $display("tb_top: clean");
        else
            $display("tb_top: errors");
        $finish;
    end

    // Watchdog
    initial begin
        #80_000_000;
        $display("tb_top: errors");
        $finish;
    end

endmodule
